@@ design/bhr_pkg.sv @@
// ----------------------------------------------------------------------------
// bhr_pkg: shared types and constants
// Operation and event codes, the command passed from the packet parser to the
// event executor, the result item and the configuration register set.
// ----------------------------------------------------------------------------
package bhr_pkg;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_TICK   = 2'd1,
    OP_BUTTON = 2'd2
  } op_t;

  // Result event codes
  typedef enum logic [2:0] {
    EV_IGNORED     = 3'd0,
    EV_LOCKED      = 3'd1,
    EV_RATE        = 3'd2,
    EV_OWN_NO_RATE = 3'd3,
    EV_STARTED     = 3'd4,
    EV_STOPPED     = 3'd5,
    EV_TIMEOUT     = 3'd6
  } ev_t;

  // Command kinds handed from front to back
  typedef enum logic [1:0] {
    CMD_PACKET = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_BUTTON = 2'd2
  } cmd_kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ON_TIME     = 2'd0,
    REG_CYCLE_TOTAL = 2'd1,
    REG_SLOPE       = 2'd2,
    REG_TIMEOUT     = 2'd3
  } reg_idx_t;

  // Advertising structure constants
  localparam logic [7:0] SERVICE_LIST_TYPE = 8'h02;
  localparam logic [7:0] VENDOR_TYPE       = 8'hFF;
  localparam logic [7:0] HR_UUID_LO        = 8'h0D;
  localparam logic [7:0] HR_UUID_HI        = 8'h18;
  localparam logic [2:0] RATE_OFFSET       = 3'd5;
  localparam logic [7:0] LAST_POS          = 8'hFF;

  // UUID match phases
  localparam logic [1:0] UUID_IDLE    = 2'd0;
  localparam logic [1:0] UUID_WANT_LO = 2'd1;
  localparam logic [1:0] UUID_WANT_HI = 2'd2;

  // Timing constants
  localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;
  localparam int          SLOPE_FRAC  = 6;

  // Register reset values
  localparam logic [10:0] ON_TIME_RESET     = 11'd200;
  localparam logic [11:0] CYCLE_TOTAL_RESET = 12'd1500;
  localparam logic [9:0]  SLOPE_RESET       = 10'd533;
  localparam logic [15:0] TIMEOUT_RESET     = 16'd10000;
  localparam logic [11:0] OFF_TIME_RESET    = 12'd200;

  // Configuration register set
  typedef struct packed {
    logic [10:0] on_time_ms;
    logic [11:0] cycle_total_ms;
    logic [9:0]  slope_q6;
    logic [15:0] timeout_ms;
  } cfg_t;

  // Command from the packet parser to the executor
  typedef struct packed {
    cmd_kind_t   kind;
    logic        service_found;
    logic [7:0]  rate;
    logic [7:0]  addr_lo;
    logic [7:0]  addr_hi;
  } cmd_t;

  // Result item
  typedef struct packed {
    ev_t         event_code;
    logic [7:0]  heart_rate;
    logic [11:0] off_time_ms;
    logic [7:0]  locked_lo;
    logic [7:0]  locked_hi;
    logic        scanning;
  } res_t;

endpackage

@@ design/ble_heart_rate_advert_filter.sv @@
// ----------------------------------------------------------------------------
// ble_heart_rate_advert_filter: heart-rate advertisement filter
// Parses advertising payloads, locks onto a heart-rate sender, extracts its
// rate and derives the LED off time; ticks and button presses run the scan.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while full stays low; a full result queue
// stalls the executor and then fills the command queue, which raises full.
// Path: an accepted item passes the combinational parser, the registered
// command queue, the combinational executor and the registered result queue.
// Reset: synchronous; registers return to defaults, queues empty, scan off.
// ----------------------------------------------------------------------------
module ble_heart_rate_advert_filter #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  // Input queue side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [7:0]  peer_addr_lo,
  input  logic [7:0]  peer_addr_hi,
  // Result queue side
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  event_code,
  output logic [7:0]  heart_rate,
  output logic [11:0] off_time_ms,
  output logic [7:0]  locked_lo,
  output logic [7:0]  locked_hi,
  output logic        scanning,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  import bhr_pkg::*;

  cfg_t cfg;
  logic accept;
  logic cmd_push;
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_full;
  logic cmd_empty;
  logic cmd_pop;
  logic res_push;
  res_t res_in;
  res_t res_out;
  logic res_full;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_time_ms     <= ON_TIME_RESET;
      cfg.cycle_total_ms <= CYCLE_TOTAL_RESET;
      cfg.slope_q6       <= SLOPE_RESET;
      cfg.timeout_ms     <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ON_TIME:     cfg.on_time_ms     <= cfg_data[10:0];
        REG_CYCLE_TOTAL: cfg.cycle_total_ms <= cfg_data[11:0];
        REG_SLOPE:       cfg.slope_q6       <= cfg_data[9:0];
        REG_TIMEOUT:     cfg.timeout_ms     <= cfg_data;
        default: begin
          cfg.timeout_ms <= cfg.timeout_ms;
        end
      endcase
    end
  end

  // Input handshake.
  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  // Packet parser.
  bhr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .operation    (operation),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .peer_addr_lo (peer_addr_lo),
    .peer_addr_hi (peer_addr_hi),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in)
  );

  // Command queue between parser and executor.
  bhr_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .full    (cmd_full),
    .empty   (cmd_empty)
  );

  // Event executor.
  bhr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Result queue in front of the output ports.
  bhr_fifo #(
    .Width ($bits(res_t)),
    .Depth (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .rd_en   (pop && !empty),
    .rd_data (res_out),
    .full    (res_full),
    .empty   (empty)
  );

  // Result ports.
  assign event_code  = res_out.event_code;
  assign heart_rate  = res_out.heart_rate;
  assign off_time_ms = res_out.off_time_ms;
  assign locked_lo   = res_out.locked_lo;
  assign locked_hi   = res_out.locked_hi;
  assign scanning    = res_out.scanning;

endmodule

@@ design/bhr_fifo.sv @@
// ----------------------------------------------------------------------------
// bhr_fifo: small register queue
// Holds items between the parser and the executor and in front of the result
// ports. A push and a pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module bhr_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [Width-1:0] wr_data,
  input  logic             rd_en,
  output logic [Width-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  // The fill count never runs past the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("queue count above depth");

endmodule

@@ design/bhr_front.sv @@
// ----------------------------------------------------------------------------
// bhr_front: advertising packet parser
// Walks the length/type structures byte by byte, tracks the heart-rate
// service UUID and the vendor rate byte, and turns each packet end, tick and
// button press into a command for the executor.
// ----------------------------------------------------------------------------
module bhr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [1:0]    operation,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  input  logic [7:0]    peer_addr_lo,
  input  logic [7:0]    peer_addr_hi,
  output logic          cmd_push,
  output bhr_pkg::cmd_t cmd
);

  import bhr_pkg::*;

  // Parse state
  logic [7:0] byte_pos;
  logic [8:0] struct_start;
  logic       service_found;
  logic       vendor_seen;
  logic [2:0] rate_countdown;
  logic [7:0] rate_captured;
  logic       type_next;
  logic       overlong;
  logic [1:0] uuid_phase;

  // Parse state after the current byte
  logic [7:0] byte_pos_next;
  logic [8:0] struct_start_next;
  logic       service_found_next;
  logic       vendor_seen_next;
  logic [2:0] rate_countdown_next;
  logic [7:0] rate_captured_next;
  logic       type_next_next;
  logic       overlong_next;
  logic [1:0] uuid_phase_next;
  logic [2:0] countdown_dec;

  // One byte of the structure walk.
  always_comb begin
    byte_pos_next       = byte_pos;
    struct_start_next   = struct_start;
    service_found_next  = service_found;
    vendor_seen_next    = vendor_seen;
    rate_countdown_next = rate_countdown;
    rate_captured_next  = rate_captured;
    type_next_next      = type_next;
    overlong_next       = overlong;
    uuid_phase_next     = uuid_phase;
    countdown_dec       = rate_countdown - 1'b1;
    if (!overlong) begin
      // UUID bytes follow the service list type byte directly.
      uuid_phase_next = UUID_IDLE;
      if (uuid_phase == UUID_WANT_LO && data_byte == HR_UUID_LO) begin
        uuid_phase_next = UUID_WANT_HI;
      end
      if (uuid_phase == UUID_WANT_HI && data_byte == HR_UUID_HI) begin
        service_found_next = 1'b1;
      end
      // Count down to the rate byte of the first vendor structure.
      if (rate_countdown != '0) begin
        rate_countdown_next = countdown_dec;
        if (countdown_dec == '0) begin
          rate_captured_next = data_byte;
        end
      end
      // Type byte, or the length byte that opens the next structure.
      if (type_next) begin
        type_next_next = 1'b0;
        if (data_byte == SERVICE_LIST_TYPE) begin
          uuid_phase_next = UUID_WANT_LO;
        end
        if (data_byte == VENDOR_TYPE && !vendor_seen) begin
          vendor_seen_next    = 1'b1;
          rate_countdown_next = RATE_OFFSET;
        end
      end else if ({1'b0, byte_pos} == struct_start) begin
        struct_start_next = {1'b0, byte_pos} + {1'b0, data_byte} + 9'd1;
        type_next_next    = (data_byte != '0);
      end
      if (byte_pos == LAST_POS) begin
        overlong_next = 1'b1;
      end else begin
        byte_pos_next = byte_pos + 1'b1;
      end
    end
  end

  // Command toward the executor.
  always_comb begin
    cmd_push          = 1'b0;
    cmd.kind          = CMD_PACKET;
    cmd.service_found = service_found_next;
    cmd.rate          = rate_captured_next;
    cmd.addr_lo       = peer_addr_lo;
    cmd.addr_hi       = peer_addr_hi;
    if (accept) begin
      case (operation)
        OP_BYTE: begin
          cmd_push = last_byte;
          cmd.kind = CMD_PACKET;
        end
        OP_TICK: begin
          cmd_push = 1'b1;
          cmd.kind = CMD_TICK;
        end
        OP_BUTTON: begin
          cmd_push = 1'b1;
          cmd.kind = CMD_BUTTON;
        end
        default: begin
          cmd_push = 1'b0;
        end
      endcase
    end
  end

  // Parse registers; a final byte returns them to the start of a packet.
  always_ff @(posedge clk) begin
    if (rst || (accept && operation == OP_BYTE && last_byte)) begin
      byte_pos       <= '0;
      struct_start   <= '0;
      service_found  <= 1'b0;
      vendor_seen    <= 1'b0;
      rate_countdown <= '0;
      rate_captured  <= '0;
      type_next      <= 1'b0;
      overlong       <= 1'b0;
      uuid_phase     <= UUID_IDLE;
    end else if (accept && operation == OP_BYTE) begin
      byte_pos       <= byte_pos_next;
      struct_start   <= struct_start_next;
      service_found  <= service_found_next;
      vendor_seen    <= vendor_seen_next;
      rate_countdown <= rate_countdown_next;
      rate_captured  <= rate_captured_next;
      type_next      <= type_next_next;
      overlong       <= overlong_next;
      uuid_phase     <= uuid_phase_next;
    end
  end

endmodule

@@ design/bhr_back.sv @@
// ----------------------------------------------------------------------------
// bhr_back: event executor
// Holds the locked peer, the scan flag, the timeout counter and the LED off
// time, and turns each command into zero or one result item.
// ----------------------------------------------------------------------------
module bhr_back (
  input  logic          clk,
  input  logic          rst,
  input  bhr_pkg::cfg_t cfg,
  input  logic          cmd_valid,
  input  bhr_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output bhr_pkg::res_t res
);

  import bhr_pkg::*;

  // Executor state
  logic [7:0]  peer_lo;
  logic [7:0]  peer_hi;
  logic        scan_active;
  logic [16:0] elapsed_ms;
  logic [11:0] off_time;

  logic [7:0]  peer_lo_next;
  logic [7:0]  peer_hi_next;
  logic        scan_active_next;
  logic [16:0] elapsed_ms_next;
  logic [11:0] off_time_next;

  logic [17:0] slope_prod;
  logic [11:0] slope_term;
  logic [13:0] off_diff;
  logic [11:0] off_calc;
  logic [16:0] elapsed_inc;
  ev_t         ev;
  logic [7:0]  rate_out;

  // A command is taken whenever the result queue has room.
  assign cmd_pop = cmd_valid && !res_full;

  // Off time for a new rate, clamped at zero.
  always_comb begin
    slope_prod = 18'(cfg.slope_q6) * 18'(cmd.rate);
    slope_term = slope_prod[SLOPE_FRAC +: 12];
    off_diff   = {2'b00, cfg.cycle_total_ms} - {3'b000, cfg.on_time_ms}
                 - {2'b00, slope_term};
    off_calc   = off_diff[13] ? '0 : off_diff[11:0];
  end

  // Saturating tick count.
  assign elapsed_inc = (elapsed_ms < ELAPSED_MAX) ? elapsed_ms + 1'b1 : elapsed_ms;

  // Command execution.
  always_comb begin
    peer_lo_next     = peer_lo;
    peer_hi_next     = peer_hi;
    scan_active_next = scan_active;
    elapsed_ms_next  = elapsed_ms;
    off_time_next    = off_time;
    ev               = EV_IGNORED;
    rate_out         = '0;
    res_push         = 1'b0;
    if (cmd_pop) begin
      case (cmd.kind)
        CMD_PACKET: begin
          res_push = 1'b1;
          if (scan_active) begin
            if (peer_lo == '0 && peer_hi == '0) begin
              if (cmd.service_found) begin
                peer_lo_next = cmd.addr_lo;
                peer_hi_next = cmd.addr_hi;
                ev           = EV_LOCKED;
              end
            end else if (cmd.addr_lo == peer_lo && cmd.addr_hi == peer_hi) begin
              elapsed_ms_next = '0;
              rate_out        = cmd.rate;
              if (cmd.rate != '0) begin
                off_time_next = off_calc;
                ev            = EV_RATE;
              end else begin
                ev = EV_OWN_NO_RATE;
              end
            end
          end
        end
        CMD_TICK: begin
          if (scan_active) begin
            if (elapsed_inc <= {1'b0, cfg.timeout_ms}) begin
              elapsed_ms_next = elapsed_inc;
            end else begin
              peer_lo_next     = '0;
              peer_hi_next     = '0;
              scan_active_next = 1'b0;
              elapsed_ms_next  = '0;
              ev               = EV_TIMEOUT;
              res_push         = 1'b1;
            end
          end
        end
        CMD_BUTTON: begin
          res_push        = 1'b1;
          elapsed_ms_next = '0;
          if (scan_active) begin
            peer_lo_next     = '0;
            peer_hi_next     = '0;
            scan_active_next = 1'b0;
            ev               = EV_STOPPED;
          end else begin
            scan_active_next = 1'b1;
            ev               = EV_STARTED;
          end
        end
        default: begin
          res_push = 1'b0;
        end
      endcase
    end
  end

  // Result item reflects the state after the update.
  always_comb begin
    res.event_code  = ev;
    res.heart_rate  = rate_out;
    res.off_time_ms = off_time_next;
    res.locked_lo   = peer_lo_next;
    res.locked_hi   = peer_hi_next;
    res.scanning    = scan_active_next;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      peer_lo     <= '0;
      peer_hi     <= '0;
      scan_active <= 1'b0;
      elapsed_ms  <= '0;
      off_time    <= OFF_TIME_RESET;
    end else begin
      peer_lo     <= peer_lo_next;
      peer_hi     <= peer_hi_next;
      scan_active <= scan_active_next;
      elapsed_ms  <= elapsed_ms_next;
      off_time    <= off_time_next;
    end
  end

  // A button press always yields a result item.
  a_button_result: assert property (@(posedge clk) disable iff (rst)
    (cmd_pop && cmd.kind == CMD_BUTTON) |-> res_push)
    else $error("button press produced no result");

  // Scanning only ends through an executed command.
  a_stop_cause: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(scan_active)) |-> $past(cmd_pop))
    else $error("scan stopped without a command");

  // A stop or timeout reports a cleared peer and an idle scan.
  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    (res_push && (res.event_code == EV_STOPPED || res.event_code == EV_TIMEOUT))
    |-> (res.locked_lo == '0 && res.locked_hi == '0 && !res.scanning))
    else $error("stop left peer or scan set");

endmodule
